FILE: hdl/bda_pkg.sv
package bda_pkg;

	// Counter and configuration widths
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	// Button count and the subset that auto-repeats
	localparam int NUM_BUTTONS = 3;
	localparam int NUM_REPEAT  = 2;

	// Configuration register indexes
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD     = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERVAL = 2'd2;

	// Reset values of the configuration registers
	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd500;
	localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = 16'd100;

	typedef logic [COUNT_WIDTH-1:0]     count_t;
	typedef logic [CFG_WIDTH-1:0]       cfg_word_t;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
	typedef logic [CMP_WIDTH-1:0]       cmp_t;

	// Registered result of one tick
	typedef struct packed {
		logic       press_decrease;
		logic       press_start;
		logic       press_increase;
		logic       repeat_decrease;
		logic       repeat_increase;
		logic [2:0] level_bits;
	} result_t;

	// Saturating increment
	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	// Zero-extend to the common compare width
	function automatic cmp_t widen_count(input count_t v);
		cmp_t r;
		r = '0;
		r[COUNT_WIDTH-1:0] = v;
		return r;
	endfunction

	function automatic cmp_t widen_cfg(input cfg_word_t v);
		cmp_t r;
		r = '0;
		r[CFG_WIDTH-1:0] = v;
		return r;
	endfunction

endpackage

FILE: hdl/bda_key_if.sv
interface bda_key_if;
	logic valid;
	logic ready;
	logic raw_decrease;
	logic raw_start;
	logic raw_increase;

	modport source (output valid, output raw_decrease, output raw_start,
		output raw_increase, input ready);
	modport sink (input valid, input raw_decrease, input raw_start,
		input raw_increase, output ready);
endinterface

FILE: hdl/bda_event_if.sv
interface bda_event_if;
	logic       valid;
	logic       ready;
	logic       press_decrease;
	logic       press_start;
	logic       press_increase;
	logic       repeat_decrease;
	logic       repeat_increase;
	logic [2:0] level_bits;

	modport source (output valid, output press_decrease, output press_start,
		output press_increase, output repeat_decrease, output repeat_increase,
		output level_bits, input ready);
	modport sink (input valid, input press_decrease, input press_start,
		input press_increase, input repeat_decrease, input repeat_increase,
		input level_bits, output ready);
endinterface

FILE: hdl/bda_cfg_if.sv
interface bda_cfg_if;
	import bda_pkg::*;

	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_word_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/button_debounce_autorepeat_top.sv
// Three-button debounce with one-shot press pulses and auto-repeat. Each request on
// the keys channel is one tick carrying the raw active-low levels of the decrease,
// start and increase buttons; every tick yields exactly one request on the events
// channel with the press pulses, the repeat pulses of decrease and increase, and
// the debounced levels after that tick. A tick is taken every clock cycle: the
// whole per-button update (saturating counters and their compares against the
// configuration) sits between the state registers and the result register, and a
// new tick is accepted whenever the result register is empty or being drained in
// the same cycle. A result appears in the cycle after its tick. Configuration writes
// are always taken; write them only while no tick is in flight.
module button_debounce_autorepeat_top (
	input  logic                clk,
	input  logic                arst_n,
	bda_key_if.sink             keys,
	bda_event_if.source         events,
	bda_cfg_if.sink             cfg
);
	import bda_pkg::*;

	// Configuration registers
	cfg_word_t debounce_q;
	cfg_word_t hold_q;
	cfg_word_t interval_q;

	// Per-button debounce state
	logic   [NUM_BUTTONS-1:0] prev_raw_q;
	logic   [NUM_BUTTONS-1:0] level_q;
	logic   [NUM_BUTTONS-1:0] reported_q;
	count_t                   stable_cnt_q [NUM_BUTTONS];

	// Per-button auto-repeat state (decrease, increase)
	logic   [NUM_REPEAT-1:0] hold_active_q;
	logic   [NUM_REPEAT-1:0] repeat_seen_q;
	count_t                  hold_cnt_q  [NUM_REPEAT];
	count_t                  since_cnt_q [NUM_REPEAT];

	// Next state
	logic   [NUM_BUTTONS-1:0] raw;
	logic   [NUM_BUTTONS-1:0] level_d;
	logic   [NUM_BUTTONS-1:0] reported_d;
	logic   [NUM_BUTTONS-1:0] press;
	count_t                   stable_cnt_d [NUM_BUTTONS];
	logic   [NUM_REPEAT-1:0]  hold_active_d;
	logic   [NUM_REPEAT-1:0]  repeat_seen_d;
	logic   [NUM_REPEAT-1:0]  rpt;
	count_t                   hold_cnt_d  [NUM_REPEAT];
	count_t                   since_cnt_d [NUM_REPEAT];
	logic   [NUM_REPEAT-1:0]  rpt_level;

	// Result register
	result_t result_q;
	result_t result_d;
	logic    out_valid_q;
	logic    accept;

	assign cfg.ready  = 1'b1;
	assign keys.ready = !out_valid_q || events.ready;
	assign accept     = keys.valid && keys.ready;

	assign raw = {keys.raw_increase, keys.raw_start, keys.raw_decrease};

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE: debounce_q <= cfg.data;
				REG_HOLD:     hold_q     <= cfg.data;
				REG_INTERVAL: interval_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Debounce and one-shot press, one button per iteration
	always_comb begin
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			stable_cnt_d[b] = (raw[b] == prev_raw_q[b]) ? sat_inc(stable_cnt_q[b]) : '0;
			level_d[b]      = level_q[b];
			reported_d[b]   = reported_q[b];
			if ((widen_count(stable_cnt_d[b]) > widen_cfg(debounce_q)) &&
					(raw[b] != level_q[b])) begin
				level_d[b] = raw[b];
				if (!raw[b]) begin
					reported_d[b] = 1'b0;
				end
			end
			press[b] = !level_d[b] && !reported_d[b];
			if (press[b]) begin
				reported_d[b] = 1'b1;
			end
		end
	end

	// Auto-repeat: decrease uses button 0, increase uses button 2
	assign rpt_level = {level_d[2], level_d[0]};

	always_comb begin
		for (int h = 0; h < NUM_REPEAT; h++) begin
			hold_active_d[h] = 1'b0;
			repeat_seen_d[h] = 1'b0;
			hold_cnt_d[h]    = '0;
			since_cnt_d[h]   = '0;
			rpt[h]           = 1'b0;
			if (!rpt_level[h]) begin
				hold_active_d[h] = 1'b1;
				if (hold_active_q[h]) begin
					hold_cnt_d[h]    = sat_inc(hold_cnt_q[h]);
					repeat_seen_d[h] = repeat_seen_q[h];
					since_cnt_d[h]   = repeat_seen_q[h] ? sat_inc(since_cnt_q[h])
						: since_cnt_q[h];
					if (widen_count(hold_cnt_d[h]) >= widen_cfg(hold_q)) begin
						if (!repeat_seen_q[h] ||
								(widen_count(since_cnt_d[h]) >= widen_cfg(interval_q))) begin
							repeat_seen_d[h] = 1'b1;
							since_cnt_d[h]   = '0;
							rpt[h]           = 1'b1;
						end
					end
				end
			end
		end
	end

	// Assemble the result of this tick
	always_comb begin
		result_d.press_decrease  = press[0];
		result_d.press_start     = press[1];
		result_d.press_increase  = press[2];
		result_d.repeat_decrease = rpt[0];
		result_d.repeat_increase = rpt[1];
		result_d.level_bits      = level_d;
	end

	// State update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= '1;
			level_q       <= '1;
			reported_q    <= '0;
			hold_active_q <= '0;
			repeat_seen_q <= '0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				stable_cnt_q[b] <= '0;
			end
			for (int h = 0; h < NUM_REPEAT; h++) begin
				hold_cnt_q[h]  <= '0;
				since_cnt_q[h] <= '0;
			end
		end else if (accept) begin
			prev_raw_q    <= raw;
			level_q       <= level_d;
			reported_q    <= reported_d;
			hold_active_q <= hold_active_d;
			repeat_seen_q <= repeat_seen_d;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				stable_cnt_q[b] <= stable_cnt_d[b];
			end
			for (int h = 0; h < NUM_REPEAT; h++) begin
				hold_cnt_q[h]  <= hold_cnt_d[h];
				since_cnt_q[h] <= since_cnt_d[h];
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (keys.ready) begin
			out_valid_q <= keys.valid;
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign events.valid           = out_valid_q;
	assign events.press_decrease  = result_q.press_decrease;
	assign events.press_start     = result_q.press_start;
	assign events.press_increase  = result_q.press_increase;
	assign events.repeat_decrease = result_q.repeat_decrease;
	assign events.repeat_increase = result_q.repeat_increase;
	assign events.level_bits      = result_q.level_bits;

endmodule
